>>> rtl/oldq_pkg.sv
// Package for the oldest-first priority queue.
// Holds the entry type, request modes and result status codes; no dependencies.
`default_nettype none

package oldq_pkg;

    localparam int ID_W      = 16;
    localparam int AGE_W     = 7;
    localparam int DEST_W    = 8;
    localparam int STATION_W = 8;
    localparam int STATUS_W  = 3;
    localparam int MODE_W    = 2;
    localparam int OCC_W     = 5;

    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LISTED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [AGE_W-1:0]  age;
        logic [DEST_W-1:0] dest;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

>>> rtl/oldq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module oldq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/oldest_first_priority_queue_unit.sv
// Top level of the oldest-first priority queue.
// Depends on oldq_pkg and oldq_ram.
`default_nettype none

// An add request completes in the cycle it is taken, so adds can arrive every cycle while the
// unit is idle; its result appears in the next cycle. A pop reads every held entry through the
// single RAM read port to find the oldest one, then closes up the entries behind it one per
// cycle. A list request gives one result per cycle after the registered RAM read. A pop or
// list on an empty queue is answered in the next cycle without the unit going busy. Results
// are strobed for a single cycle and cannot be held off by the receiver.
module oldest_first_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [oldq_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [oldq_pkg::ID_W-1:0]     i_entry_id,
    input  wire logic [oldq_pkg::AGE_W-1:0]    i_age_key,
    input  wire logic [oldq_pkg::DEST_W-1:0]   i_dest_code,
    input  wire logic                          i_cfg_we,
    input  wire logic [oldq_pkg::STATION_W-1:0] i_cfg_wdata,
    output logic                               o_valid,
    output logic [oldq_pkg::STATUS_W-1:0]      o_status,
    output logic [oldq_pkg::ID_W-1:0]          o_out_id,
    output logic [oldq_pkg::AGE_W-1:0]         o_out_age,
    output logic [oldq_pkg::DEST_W-1:0]        o_out_dest,
    output logic [oldq_pkg::STATION_W-1:0]     o_out_station,
    output logic [oldq_pkg::OCC_W-1:0]         o_occupancy,
    output logic                               o_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LIST  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_idx, n_idx;
    logic                                r_pend, n_pend;
    logic [AW-1:0]                       r_pend_idx, n_pend_idx;
    oldq_pkg::t_entry                    r_best, n_best;
    logic [AW-1:0]                       r_best_idx, n_best_idx;
    logic [oldq_pkg::STATION_W-1:0]      r_station;

    logic                                r_valid, n_valid;
    logic [oldq_pkg::STATUS_W-1:0]       r_status, n_status;
    logic [oldq_pkg::ID_W-1:0]           r_id, n_id;
    logic [oldq_pkg::AGE_W-1:0]          r_age, n_age;
    logic [oldq_pkg::DEST_W-1:0]         r_dest, n_dest;
    logic [oldq_pkg::STATION_W-1:0]      r_stat_out, n_stat_out;
    logic [oldq_pkg::OCC_W-1:0]          r_occ, n_occ;
    logic                                r_last, n_last;

    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    oldq_pkg::t_entry                    wr_data;
    logic [AW-1:0]                       rd_addr;
    oldq_pkg::t_entry                    rd_data;

    logic                                pend_last;
    logic                                better;
    logic [CW-1:0]                       idx_next;

    oldq_ram #(
        .WIDTH (oldq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign pend_last = (CW'(r_pend_idx) == (r_count - ONE_C));
    assign better    = (r_pend_idx == '0) || (rd_data.age > r_best.age);
    assign idx_next  = r_idx + ONE_C;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_best     = r_best;
        n_best_idx = r_best_idx;

        n_valid    = 1'b0;
        n_status   = oldq_pkg::ST_ADDED;
        n_id       = '0;
        n_age      = '0;
        n_dest     = '0;
        n_stat_out = '0;
        n_occ      = oldq_pkg::OCC_W'(r_count);
        n_last     = 1'b1;

        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = '{id: i_entry_id, age: i_age_key, dest: i_dest_code};
        rd_addr    = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        oldq_pkg::MODE_ADD: begin
                            n_valid = 1'b1;
                            if (r_count == DEPTH_C) begin
                                n_status = oldq_pkg::ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                n_count  = r_count + ONE_C;
                                n_status = oldq_pkg::ST_ADDED;
                                n_occ    = oldq_pkg::OCC_W'(r_count + ONE_C);
                            end
                        end
                        oldq_pkg::MODE_POP, oldq_pkg::MODE_LIST: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = oldq_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = (i_mode == oldq_pkg::MODE_POP) ? S_SCAN : S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST, S_SCAN: begin
                if (r_idx < r_count) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = idx_next;
                end
                if (r_pend) begin
                    if (r_state == S_LIST) begin
                        n_valid  = 1'b1;
                        n_status = oldq_pkg::ST_LISTED;
                        n_id     = rd_data.id;
                        n_age    = rd_data.age;
                        n_last   = pend_last;
                        if (pend_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        if (better) begin
                            n_best     = rd_data;
                            n_best_idx = r_pend_idx;
                        end
                        if (pend_last) begin
                            n_state = S_SHIFT;
                            n_idx   = better ? CW'(r_pend_idx) : CW'(r_best_idx);
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (idx_next < r_count) begin
                    rd_addr    = idx_next[AW-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = idx_next;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_idx;
                    wr_data = rd_data;
                end
                if (!(idx_next < r_count) && !r_pend) begin
                    n_valid    = 1'b1;
                    n_status   = oldq_pkg::ST_DISPATCHED;
                    n_id       = r_best.id;
                    n_age      = r_best.age;
                    n_dest     = r_best.dest;
                    n_stat_out = r_station;
                    n_count    = r_count - ONE_C;
                    n_occ      = oldq_pkg::OCC_W'(r_count - ONE_C);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_valid   <= 1'b0;
            r_station <= oldq_pkg::STATION_W'(65);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_station <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_status   <= n_status;
        r_id       <= n_id;
        r_age      <= n_age;
        r_dest     <= n_dest;
        r_stat_out <= n_stat_out;
        r_occ      <= n_occ;
        r_last     <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_id      = r_id;
    assign o_out_age     = r_age;
    assign o_out_dest    = r_dest;
    assign o_out_station = r_stat_out;
    assign o_occupancy   = r_occ;
    assign o_last        = r_last;

endmodule

`default_nettype wire
